@@ rtl/core/fdr_pkg.sv @@
// Shared constants, payload types and step functions for the Fresnel reflectance pipeline.
`default_nettype none
package fdr_pkg;

  localparam int COS_FRAC_BITS = 15;
  localparam int COS_W         = 16;
  localparam int ETA_W         = 16;
  localparam int REFL_W        = 17;
  localparam int CFG_IDX_W     = 2;

  localparam int SIN_DIV_STEPS = 30;
  localparam int SQRT_STEPS    = 16;
  localparam int RATIO_STEPS   = 31;

  localparam logic [ETA_W-1:0]  ETA_INC_RESET = 16'd4096;
  localparam logic [ETA_W-1:0]  ETA_TRN_RESET = 16'd6144;
  localparam logic [15:0]       ONE_Q15       = 16'h8000;
  localparam logic [30:0]       ONE_Q30       = 31'h4000_0000;
  localparam logic [31:0]       ONE_Q31       = 32'h8000_0000;
  localparam logic [REFL_W-1:0] REFL_ONE      = 17'h1_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ETA_INCIDENT = 2'd0,
    REG_ETA_TRANSMIT = 2'd1
  } cfg_reg_e;

  // Per-item context carried alongside the arithmetic.
  typedef struct packed {
    logic        tir;
    logic [15:0] c;
    logic [15:0] ni;
    logic [15:0] nt;
  } item_t;

  // Restoring divider state for the transmitted sine squared.
  typedef struct packed {
    logic [31:0] rem;
    logic [29:0] low;
    logic [29:0] q;
    logic [31:0] den;
  } sdiv_t;

  typedef struct packed {
    logic [30:0] x;
    logic [30:0] res;
  } sqrt_t;

  // Restoring divider state for one amplitude ratio.
  typedef struct packed {
    logic        zero;
    logic [31:0] rem;
    logic [31:0] den;
    logic [31:0] q;
  } rdiv_t;

  function automatic sdiv_t sdiv_step(sdiv_t s);
    sdiv_t       n;
    logic [32:0] r2;
    logic        ge;
    r2    = {s.rem, s.low[29]};
    ge    = r2 >= {1'b0, s.den};
    n.den = s.den;
    n.rem = ge ? 32'(r2 - {1'b0, s.den}) : r2[31:0];
    n.low = {s.low[28:0], 1'b0};
    n.q   = {s.q[28:0], ge};
    return n;
  endfunction

  // One digit of the square root; the trial bit is 4^(15-k).
  function automatic sqrt_t sqrt_step(sqrt_t s, int k);
    sqrt_t       n;
    logic [31:0] bitv;
    logic [31:0] trial;
    logic        ge;
    bitv  = 32'd1 << (30 - 2 * k);
    trial = {1'b0, s.res} + bitv;
    ge    = {1'b0, s.x} >= trial;
    n.x   = ge ? 31'({1'b0, s.x} - trial) : s.x;
    n.res = ge ? 31'(({1'b0, s.res} >> 1) + bitv) : (s.res >> 1);
    return n;
  endfunction

  function automatic rdiv_t rdiv_init(logic [30:0] a, logic [30:0] b);
    rdiv_t       n;
    logic [31:0] num;
    logic        ge;
    n.den  = {1'b0, a} + {1'b0, b};
    num    = (a > b) ? {1'b0, a - b} : {1'b0, b - a};
    n.zero = n.den == 32'd0;
    ge     = num >= n.den;
    n.rem  = ge ? num - n.den : num;
    n.q    = {31'd0, ge};
    return n;
  endfunction

  function automatic rdiv_t rdiv_step(rdiv_t s);
    rdiv_t       n;
    logic [32:0] r2;
    logic        ge;
    r2     = {s.rem, 1'b0};
    ge     = r2 >= {1'b0, s.den};
    n.zero = s.zero;
    n.den  = s.den;
    n.rem  = ge ? 32'(r2 - {1'b0, s.den}) : r2[31:0];
    n.q    = {s.q[30:0], ge};
    return n;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fdr_front.sv @@
// Front stages: cosine magnitude, index swap, incident sine squared and the divider setup.
`default_nettype none
module fdr_front import fdr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [COS_W-1:0] cos_i,
  input  logic [ETA_W-1:0]        eta_inc_i,
  input  logic [ETA_W-1:0]        eta_trn_i,
  output logic                    valid_o,
  output item_t                   item_o,
  output sdiv_t                   div_o
);

  logic        neg;
  logic        entering;
  logic [16:0] mag;
  logic [31:0] cs;
  item_t       it1_d;

  logic        v1_q, v2_q, v3_q, v4_q;
  item_t       it1_q, it2_q, it3_q, it4_q;
  logic [30:0] cc_q;
  logic [31:0] ni2_q, nt2_q, nt2b_q;
  logic [62:0] prod_q;
  sdiv_t       div_q;

  logic [30:0] s2;
  logic [32:0] hi;
  logic        tir_big;

  always_comb begin
    neg      = cos_i[COS_W-1];
    entering = !neg && (cos_i != '0);
    mag      = neg ? 17'(17'h1_0000 - {1'b0, cos_i}) : {1'b0, cos_i};
    cs       = (COS_FRAC_BITS >= 15) ? ({15'd0, mag} >> (COS_FRAC_BITS - 15))
                                     : ({15'd0, mag} << (15 - COS_FRAC_BITS));
    it1_d.c   = (cs > {16'd0, ONE_Q15}) ? ONE_Q15 : cs[15:0];
    it1_d.ni  = entering ? eta_inc_i : eta_trn_i;
    it1_d.nt  = entering ? eta_trn_i : eta_inc_i;
    it1_d.tir = (entering ? eta_trn_i : eta_inc_i) == '0;
  end

  always_comb begin
    s2      = ONE_Q30 - cc_q;
    hi      = prod_q[62:30];
    tir_big = hi >= {1'b0, nt2b_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q  <= it1_d;
      it2_q  <= it1_q;
      cc_q   <= 31'({16'd0, it1_q.c} * {16'd0, it1_q.c});
      ni2_q  <= {16'd0, it1_q.ni} * {16'd0, it1_q.ni};
      nt2_q  <= {16'd0, it1_q.nt} * {16'd0, it1_q.nt};
      it3_q  <= it2_q;
      prod_q <= 63'(64'(ni2_q) * 64'(s2));
      nt2b_q <= nt2_q;
      it4_q  <= '{tir: it3_q.tir | tir_big, c: it3_q.c, ni: it3_q.ni, nt: it3_q.nt};
      div_q  <= '{rem: hi[31:0], low: prod_q[29:0], q: 30'd0, den: nt2b_q};
    end
  end

  assign valid_o = v4_q;
  assign item_o  = it4_q;
  assign div_o   = div_q;

endmodule
`default_nettype wire

@@ rtl/core/fdr_sin_div.sv @@
// Pipelined restoring divider giving the transmitted sine squared, one quotient bit a stage.
`default_nettype none
module fdr_sin_div import fdr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  item_t       item_i,
  input  sdiv_t       div_i,
  output logic        valid_o,
  output item_t       item_o,
  output logic [29:0] quot_o
);

  logic  v_q  [SIN_DIV_STEPS];
  item_t it_q [SIN_DIV_STEPS];
  sdiv_t d_q  [SIN_DIV_STEPS];

  for (genvar g = 0; g < SIN_DIV_STEPS; g++) begin : g_step
    logic  v_in;
    item_t it_in;
    sdiv_t d_in;
    if (g == 0) begin : g_first
      assign v_in  = valid_i;
      assign it_in = item_i;
      assign d_in  = div_i;
    end else begin : g_next
      assign v_in  = v_q[g-1];
      assign it_in = it_q[g-1];
      assign d_in  = d_q[g-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        it_q[g] <= it_in;
        d_q[g]  <= sdiv_step(d_in);
      end
    end
  end

  assign valid_o = v_q[SIN_DIV_STEPS-1];
  assign item_o  = it_q[SIN_DIV_STEPS-1];
  assign quot_o  = d_q[SIN_DIV_STEPS-1].q;

endmodule
`default_nettype wire

@@ rtl/core/fdr_sqrt.sv @@
// Pipelined integer square root of the transmitted cosine squared, one result bit a stage.
`default_nettype none
module fdr_sqrt import fdr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  item_t       item_i,
  input  logic [29:0] st2_i,
  output logic        valid_o,
  output item_t       item_o,
  output logic [15:0] ct_o
);

  logic  v0_q;
  item_t it0_q;
  sqrt_t s0_q;

  logic  v_q  [SQRT_STEPS];
  item_t it_q [SQRT_STEPS];
  sqrt_t s_q  [SQRT_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it0_q <= item_i;
      s0_q  <= '{x: ONE_Q30 - {1'b0, st2_i}, res: 31'd0};
    end
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    logic  v_in;
    item_t it_in;
    sqrt_t s_in;
    if (g == 0) begin : g_first
      assign v_in  = v0_q;
      assign it_in = it0_q;
      assign s_in  = s0_q;
    end else begin : g_next
      assign v_in  = v_q[g-1];
      assign it_in = it_q[g-1];
      assign s_in  = s_q[g-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        it_q[g] <= it_in;
        s_q[g]  <= sqrt_step(s_in, g);
      end
    end
  end

  assign valid_o = v_q[SQRT_STEPS-1];
  assign item_o  = it_q[SQRT_STEPS-1];
  assign ct_o    = s_q[SQRT_STEPS-1].res[15:0];

endmodule
`default_nettype wire

@@ rtl/core/fdr_ratio.sv @@
// Amplitude ratios by two pipelined dividers, then their squares and the saturated mean.
`default_nettype none
module fdr_ratio import fdr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  item_t             item_i,
  input  logic [15:0]       ct_i,
  output logic              valid_o,
  output logic              tir_o,
  output logic [REFL_W-1:0] refl_o
);

  logic        va_q, vb_q, vs_q, vr_q;
  logic        tira_q, tirb_q, tirs_q, tirr_q;
  logic [30:0] a1_q, b1_q, a2_q, b2_q;
  rdiv_t       pa_q, pb_q;
  logic [62:0] sqa_q, sqb_q;
  logic [REFL_W-1:0] refl_q;

  logic        v_q   [RATIO_STEPS];
  logic        tir_q [RATIO_STEPS];
  rdiv_t       ra_q  [RATIO_STEPS];
  rdiv_t       rb_q  [RATIO_STEPS];

  logic [31:0] qa, qb;
  logic [63:0] sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vs_q <= 1'b0;
      vr_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vs_q <= v_q[RATIO_STEPS-1];
      vr_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tira_q <= item_i.tir;
      a1_q   <= 31'({16'd0, item_i.nt} * {16'd0, item_i.c});
      b1_q   <= 31'({16'd0, item_i.ni} * {16'd0, ct_i});
      a2_q   <= 31'({16'd0, item_i.ni} * {16'd0, item_i.c});
      b2_q   <= 31'({16'd0, item_i.nt} * {16'd0, ct_i});
      tirb_q <= tira_q;
      pa_q   <= rdiv_init(a1_q, b1_q);
      pb_q   <= rdiv_init(a2_q, b2_q);
    end
  end

  for (genvar g = 0; g < RATIO_STEPS; g++) begin : g_step
    logic  v_in, tir_in;
    rdiv_t a_in, b_in;
    if (g == 0) begin : g_first
      assign v_in   = vb_q;
      assign tir_in = tirb_q;
      assign a_in   = pa_q;
      assign b_in   = pb_q;
    end else begin : g_next
      assign v_in   = v_q[g-1];
      assign tir_in = tir_q[g-1];
      assign a_in   = ra_q[g-1];
      assign b_in   = rb_q[g-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tir_q[g] <= tir_in;
        ra_q[g]  <= rdiv_step(a_in);
        rb_q[g]  <= rdiv_step(b_in);
      end
    end
  end

  // A ratio whose denominator is zero counts as magnitude one.
  always_comb begin
    qa  = ra_q[RATIO_STEPS-1].zero ? ONE_Q31 : ra_q[RATIO_STEPS-1].q;
    qb  = rb_q[RATIO_STEPS-1].zero ? ONE_Q31 : rb_q[RATIO_STEPS-1].q;
    sum = {1'b0, sqa_q} + {1'b0, sqb_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tirs_q <= tir_q[RATIO_STEPS-1];
      sqa_q  <= 63'(64'(qa) * 64'(qa));
      sqb_q  <= 63'(64'(qb) * 64'(qb));
      tirr_q <= tirs_q;
      refl_q <= (sum[63:47] > REFL_ONE) ? REFL_ONE : sum[63:47];
    end
  end

  assign valid_o = vr_q;
  assign tir_o   = tirr_q;
  assign refl_o  = refl_q;

endmodule
`default_nettype wire

@@ rtl/core/fresnel_dielectric_reflectance_top.sv @@
// Top level of the unpolarized dielectric Fresnel reflectance pipeline.
//
//   Channel  Direction  Handshake                  Payload
//   input    in         in_valid_i / in_stall_o    cos_incidence_i
//   output   out        out_valid_o / out_stall_i  reflectance_o, total_internal_o
//   config   in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item enters per cycle unless a waiting result is stalled.
// Most of the pipeline depth lies in the three bit-per-stage units: the sine divider (30 stages),
// the square root (16 stages) and the ratio dividers (31 stages).
// Reset empties the pipeline and loads the indices with 1.0 and 1.5.
// A stalled result freezes the whole pipeline, so in_stall_o follows out_stall_i
// while a result waits; nothing is lost or repeated.
`default_nettype none
module fresnel_dielectric_reflectance_top import fdr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [COS_W-1:0] cos_incidence_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [REFL_W-1:0]       reflectance_o,
  output logic                    total_internal_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ETA_W-1:0]        cfg_data_i
);

  logic [ETA_W-1:0] eta_inc_q, eta_trn_q;
  logic             en;

  logic        f_valid, d_valid, s_valid, r_valid, r_tir;
  item_t       f_item, d_item, s_item;
  sdiv_t       f_div;
  logic [29:0] st2;
  logic [15:0] ct;
  logic [REFL_W-1:0] r_refl;

  logic              out_valid_q;
  logic [REFL_W-1:0] refl_q;
  logic              tir_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_inc_q <= ETA_INC_RESET;
      eta_trn_q <= ETA_TRN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ETA_INCIDENT: eta_inc_q <= cfg_data_i;
        REG_ETA_TRANSMIT: eta_trn_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fdr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .cos_i     (cos_incidence_i),
    .eta_inc_i (eta_inc_q),
    .eta_trn_i (eta_trn_q),
    .valid_o   (f_valid),
    .item_o    (f_item),
    .div_o     (f_div)
  );

  fdr_sin_div u_sin_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .item_i  (f_item),
    .div_i   (f_div),
    .valid_o (d_valid),
    .item_o  (d_item),
    .quot_o  (st2)
  );

  fdr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .item_i  (d_item),
    .st2_i   (st2),
    .valid_o (s_valid),
    .item_o  (s_item),
    .ct_o    (ct)
  );

  fdr_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .item_i  (s_item),
    .ct_i    (ct),
    .valid_o (r_valid),
    .tir_o   (r_tir),
    .refl_o  (r_refl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= r_valid;
    end
  end

  // Total internal reflection overrides whatever the ratio path produced.
  always_ff @(posedge clk_i) begin
    if (en) begin
      tir_q  <= r_tir;
      refl_q <= r_tir ? REFL_ONE : r_refl;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reflectance_o    = refl_q;
  assign total_internal_o = tir_q;

endmodule
`default_nettype wire

@@ rtl/core/fdr_checker.sv @@
// Port-level checker for the reflectance pipeline and its bind to the top level.
`default_nettype none
module fdr_props import fdr_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic signed [COS_W-1:0] cos_incidence_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [REFL_W-1:0]       reflectance_o,
  input logic                    total_internal_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(cos_incidence_i))
    else $error("input transfer changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transfer dropped while stalled");

  a_refl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> reflectance_o <= REFL_ONE)
    else $error("reflectance above one");

  a_tir_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && total_internal_o |-> reflectance_o == REFL_ONE)
    else $error("total internal reflection without full reflectance");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

endmodule

bind fresnel_dielectric_reflectance_top fdr_props u_fdr_props (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .cos_incidence_i  (cos_incidence_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .reflectance_o    (reflectance_o),
  .total_internal_o (total_internal_o)
);
`default_nettype wire

@@ test/fdr_checker.sv @@
// Checker that predicts each reflectance result and compares it with the block's output.
`timescale 1ns / 100ps
module fdr_checker import fdr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [COS_W-1:0] cos_incidence_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [REFL_W-1:0]       reflectance_i,
  input  logic                    total_internal_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ETA_W-1:0]        cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic [REFL_W-1:0] refl;
    logic              tir;
  } refl_t;

  logic [ETA_W-1:0] eta_inc;
  logic [ETA_W-1:0] eta_trn;
  refl_t            expected_q[$];

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] amp_ratio(logic [63:0] a, logic [63:0] b);
    logic [63:0] den;
    logic [63:0] num;
    den = a + b;
    num = (a > b) ? a - b : b - a;
    if (den == 0) return 64'd1 << 31;
    return (num << 31) / den;
  endfunction

  function automatic refl_t reflectance(logic [15:0] raw);
    refl_t       r;
    logic        entering;
    logic [63:0] mag, c, ni, nt, s2, st2, ct, qa, qb, sum;
    if (raw[15]) begin
      entering = 1'b0;
      mag = 64'h10000 - raw;
    end else begin
      entering = raw != 0;
      mag = raw;
    end
    c = mag >> (COS_FRAC_BITS - 15);
    if (c > 64'd32768) c = 64'd32768;
    ni = entering ? eta_inc : eta_trn;
    nt = entering ? eta_trn : eta_inc;
    r.refl = REFL_ONE;
    r.tir = 1'b1;
    if (nt == 0) return r;
    s2 = (64'd1 << 30) - c * c;
    st2 = (ni * ni * s2) / (nt * nt);
    if (st2 >= (64'd1 << 30)) return r;
    ct = int_sqrt((64'd1 << 30) - st2);
    qa = amp_ratio(nt * c, ni * ct);
    qb = amp_ratio(ni * c, nt * ct);
    sum = (qa * qa + qb * qb) >> 47;
    r.refl = (sum > 64'd65536) ? REFL_ONE : sum[REFL_W-1:0];
    r.tir = 1'b0;
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    refl_t e;
    int    errs;
    errs = 0;
    if (!rst_ni) begin
      eta_inc <= ETA_INC_RESET;
      eta_trn <= ETA_TRN_RESET;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) expected_q.push_back(reflectance(cos_incidence_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer");
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (reflectance_i !== e.refl) begin
            $error("reflectance: expected %0d, got %0d", e.refl, reflectance_i);
            errs++;
          end
          if (total_internal_i !== e.tir) begin
            $error("total_internal: expected %0d, got %0d", e.tir, total_internal_i);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_ETA_INCIDENT) eta_inc <= cfg_data_i;
        else if (cfg_index_i == REG_ETA_TRANSMIT) eta_trn <= cfg_data_i;
      end
    end
  end

endmodule

@@ test/tb_top.sv @@
// Testbench top: drives cosines and index settings, and gives the verdict.
`timescale 1ns / 100ps
module tb_top;
  import fdr_pkg::*;

  localparam int LATENCY = 87;
  localparam int LIMIT   = 400000;
  localparam int HOLD_CYCLES = 300;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [COS_W-1:0] cos_incidence;
  logic                    out_valid;
  logic                    out_stall;
  logic [REFL_W-1:0]       reflectance;
  logic                    total_internal;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [ETA_W-1:0]        cfg_data;
  int                      fail_count;
  int                      pending;
  int                      cycles = 0;
  bit                      hold_off;
  int                      hold_left;
  bit                      hold_done;

  fresnel_dielectric_reflectance_top uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .cos_incidence_i(cos_incidence),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .reflectance_o(reflectance), .total_internal_o(total_internal),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  fdr_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .cos_incidence_i(cos_incidence),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .reflectance_i(reflectance), .total_internal_i(total_internal),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stall pattern; once requested, the receiver holds off for a counted stretch.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_off && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (cycles % 512 < 200) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_cos(logic [15:0] v);
    in_valid <= 1'b1;
    cos_incidence <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      cos_incidence <= 16'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_burst(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: send_cos(16'($urandom_range(0, 12) + 16'h7ff8));
        1: send_cos(16'(16'h8000 + $urandom_range(0, 12)));
        2: send_cos(16'($signed($urandom_range(0, 64)) - 32));
        default: send_cos(16'($urandom));
      endcase
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        idle_gap();
      end else begin
        burst--;
      end
    end
  endtask

  initial begin
    logic [15:0] directed[$];
    logic [15:0] eta_sets[6][2];
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    cos_incidence = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ETA_INCIDENT;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both directions at the extremes, zero, and near grazing angles.
    directed = '{16'h7fff, 16'h8000, 16'h8001, 16'h0000, 16'hffff, 16'h0001,
                 16'h4000, 16'hc000, 16'h5a82, 16'ha57e, 16'h0100, 16'hff00,
                 16'h5555, 16'haaaa, 16'h0010, 16'hfff0};
    foreach (directed[i]) send_cos(directed[i]);
    random_burst(40);

    // Long hold-off while items keep coming, so the pipeline backs up.
    hold_off = 1'b1;
    random_burst(110);
    hold_off = 1'b0;
    drain();

    eta_sets = '{'{16'd1, 16'd65535}, '{16'd65535, 16'd1}, '{16'd6144, 16'd4096},
                 '{16'd4096, 16'd4096}, '{16'd5461, 16'd9830}, '{16'd4096, 16'd6144}};
    foreach (eta_sets[k]) begin
      write_reg(REG_ETA_INCIDENT, eta_sets[k][0]);
      write_reg(REG_ETA_TRANSMIT, eta_sets[k][1]);
      send_cos(16'h7fff);
      send_cos(16'h8000);
      send_cos(16'h0000);
      random_burst(45);
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/fdr_pkg.sv
rtl/core/fdr_front.sv
rtl/core/fdr_sin_div.sv
rtl/core/fdr_sqrt.sv
rtl/core/fdr_ratio.sv
rtl/core/fresnel_dielectric_reflectance_top.sv
rtl/core/fdr_checker.sv
test/fdr_checker.sv
test/tb_top.sv
